// ===== hw/rtl/cts_pkg.sv =====
// Clutch torque solver shared types and constants.
// Used by the controller, the datapath, the serial units and the top level.
package cts_pkg;

  localparam int MUL_A_W   = 88;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = 5;
  localparam int DIV_W     = 128;
  localparam int DIV_CNT_W = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] MODE_CONSTRAINT = 2'd0;
  localparam logic [1:0] MODE_SPRING     = 2'd1;
  localparam logic [1:0] MODE_FLUID      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIM_MODE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_FACTOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUTCH_STIFFNESS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_RATIO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VISCOUS_DAMPING  = 3'd4;

  typedef enum logic [4:0] {
    STP_CAP1, STP_CAP2, STP_JMUL, STP_JDIV, STP_CMUL, STP_CDIV, STP_FNUM,
    STP_KMUL, STP_KDIV, STP_KJ, STP_SQRT, STP_DAMP, STP_ADT, STP_SS, STP_T1,
    STP_T2, STP_NJ, STP_AD, STP_QDIV, STP_DELTA, STP_ANGLE
  } step_t;

  typedef enum logic [1:0] {CS_IDLE, CS_LAUNCH, CS_WAIT, CS_FINISH} ctrl_state_t;

  typedef struct packed {
    logic  load;
    logic  start;
    logic  capture;
    logic  finish;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic       done;
    logic [1:0] mode;
  } sts_t;

endpackage

// ===== hw/rtl/cts_mul.sv =====
// Serial shift-add multiplier, one multiplier bit per cycle.
// Depends on cts_pkg for operand widths.
module cts_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cts_pkg::MUL_A_W-1:0] a,
  input  logic [cts_pkg::MUL_B_W-1:0] b,
  output logic                        done,
  output logic [cts_pkg::MUL_P_W-1:0] prod
);
  localparam int PW = cts_pkg::MUL_P_W;
  localparam int CW = cts_pkg::MUL_CNT_W;

  logic [PW-1:0]               acc_r, acc_nxt, sh_r, sh_nxt;
  logic [cts_pkg::MUL_B_W-1:0] b_r, b_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      sh_nxt   = PW'(a);
      b_nxt    = b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + sh_r;
      end
      sh_nxt  = sh_r << 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(cts_pkg::MUL_B_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

// ===== hw/rtl/cts_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on cts_pkg for the word width.
module cts_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cts_pkg::DIV_W-1:0] num,
  input  logic [cts_pkg::DIV_W-1:0] den,
  output logic                      done,
  output logic [cts_pkg::DIV_W-1:0] quo
);
  localparam int DW = cts_pkg::DIV_W;
  localparam int CW = cts_pkg::DIV_CNT_W;

  logic [DW-1:0] nq_r, nq_nxt, r_r, r_nxt, d_r, d_nxt, rs;
  logic [DW:0]   diff;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    rs       = {r_r[DW-2:0], nq_r[DW-1]};
    diff     = {1'b0, rs} - {1'b0, d_r};
    nq_nxt   = nq_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      nq_nxt   = num;
      r_nxt    = '0;
      d_nxt    = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        r_nxt  = diff[DW-1:0];
        nq_nxt = {nq_r[DW-2:0], 1'b1};
      end else begin
        r_nxt  = rs;
        nq_nxt = {nq_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    nq_r <= nq_nxt;
    r_r  <= r_nxt;
    d_r  <= d_nxt;
  end

  assign done = done_r;
  assign quo  = nq_r;
endmodule

// ===== hw/rtl/cts_datapath.sv =====
// Datapath: configuration, item and work registers, serial root, shared mul and div.
// Depends on cts_pkg, cts_mul and cts_div; steered by cts_ctrl commands.
module cts_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cts_pkg::cmd_t                 cmd,
  output cts_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic [cts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic [23:0]                   in_delta_time,
  input  logic [16:0]                   in_clutch_pedal,
  input  logic signed [31:0]            in_gearbox_speed,
  input  logic [31:0]                   in_gearbox_inertia,
  input  logic                          in_gear_engaged,
  input  logic [31:0]                   in_shaft_stiffness,
  input  logic signed [31:0]            in_engine_speed,
  input  logic [31:0]                   in_engine_inertia,
  input  logic [31:0]                   in_engine_peak_torque,
  output logic signed [31:0]            out_clutch_torque,
  output logic                          out_capacity_limited
);
  localparam int AW = cts_pkg::MUL_A_W;
  localparam int BW = cts_pkg::MUL_B_W;
  localparam int PW = cts_pkg::MUL_P_W;
  localparam int DW = cts_pkg::DIV_W;

  logic [1:0]  mode_r;
  logic [15:0] capf_r, zeta_r;
  logic [31:0] kc_r, dv_r;

  logic [23:0] dt_r;
  logic [31:0] jg_r, je_r, ks_r, peak_r, smag_r;
  logic [16:0] lock_r;
  logic        sneg_r;
  logic [31:0] angle_r;

  logic [36:0]  cap_r;
  logic [31:0]  j_r, k_r, ss_r, delta_r;
  logic [63:0]  p_r, mag_r;
  logic [33:0]  s_r;
  logic [40:0]  a_r;
  logic [66:0]  t1_r;
  logic [AW-1:0] num_r;
  logic [PW-1:0] nj_r;
  logic [64:0]  ad_r;
  logic         neg_r, lim_r;
  logic [31:0]  torque_r;
  logic         limited_r;

  logic [67:0] sq_x_r;
  logic [33:0] sq_root_r;
  logic [35:0] sq_rem_r;
  logic [5:0]  sq_cnt_r;
  logic        sq_busy_r, sq_done_r;
  logic [37:0] sq_remw, sq_trial;

  logic [16:0] pedal_c, lock_c;
  logic [32:0] slip_c, slip_neg_c;
  logic [32:0] jsum, ksum;
  logic [31:0] amag;
  logic [33:0] delta_s, asum, asum_neg;
  logic [32:0] asum_mag;

  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] mul_prod;
  logic [DW-1:0] div_n, div_d, div_q;
  logic          mul_start, div_start, sq_start, mul_done, div_done;
  logic          is_div, is_sqrt;

  logic [63:0]   q_sat, cdiv_mag, qdiv_mag, sel_mag, clamp_mag;
  logic          lim_c;
  logic [AW-1:0] t1w, t2w, num_c;
  logic          neg_c;
  logic [33:0]   angm;
  logic [31:0]   na_c, pack_c;

  always_comb begin
    pedal_c    = (in_clutch_pedal > 17'd65536) ? 17'd65536 : in_clutch_pedal;
    lock_c     = in_gear_engaged ? 17'd65536 - pedal_c : 17'd0;
    slip_c     = {in_engine_speed[31], in_engine_speed} -
                 {in_gearbox_speed[31], in_gearbox_speed};
    slip_neg_c = 33'd0 - slip_c;
    jsum       = {1'b0, jg_r} + {1'b0, je_r};
    ksum       = {1'b0, ks_r} + {1'b0, kc_r};
    amag       = angle_r[31] ? 32'd0 - angle_r : angle_r;
    delta_s    = sneg_r ? 34'd0 - {2'd0, delta_r} : {2'd0, delta_r};
    asum       = {{2{angle_r[31]}}, angle_r} + delta_s;
    asum_neg   = 34'd0 - asum;
    asum_mag   = asum[33] ? asum_neg[32:0] : asum[32:0];
  end

  always_comb begin
    is_div  = (cmd.step == cts_pkg::STP_JDIV) || (cmd.step == cts_pkg::STP_KDIV) ||
              (cmd.step == cts_pkg::STP_CDIV) || (cmd.step == cts_pkg::STP_QDIV);
    is_sqrt = (cmd.step == cts_pkg::STP_SQRT);
    mul_a   = '0;
    mul_b   = '0;
    div_n   = '0;
    div_d   = '0;
    case (cmd.step)
      cts_pkg::STP_CAP1:  begin mul_a = AW'(peak_r);   mul_b = BW'(capf_r);  end
      cts_pkg::STP_CAP2:  begin mul_a = AW'(cap_r);    mul_b = BW'(lock_r);  end
      cts_pkg::STP_JMUL:  begin mul_a = AW'(jg_r);     mul_b = je_r;         end
      cts_pkg::STP_CMUL:  begin mul_a = AW'(smag_r);   mul_b = j_r;          end
      cts_pkg::STP_FNUM:  begin mul_a = AW'(dv_r);     mul_b = smag_r;       end
      cts_pkg::STP_KMUL:  begin mul_a = AW'(ks_r);     mul_b = kc_r;         end
      cts_pkg::STP_KJ:    begin mul_a = AW'(k_r);      mul_b = j_r;          end
      cts_pkg::STP_DAMP:  begin mul_a = AW'(s_r);      mul_b = BW'(zeta_r);  end
      cts_pkg::STP_ADT:   begin mul_a = AW'(k_r);      mul_b = BW'(dt_r);    end
      cts_pkg::STP_SS:    begin mul_a = AW'(smag_r);   mul_b = BW'(lock_r);  end
      cts_pkg::STP_T1:    begin mul_a = AW'(k_r);      mul_b = amag;         end
      cts_pkg::STP_T2:    begin mul_a = AW'(a_r);      mul_b = ss_r;         end
      cts_pkg::STP_NJ:    begin mul_a = num_r;         mul_b = j_r;          end
      cts_pkg::STP_AD:    begin mul_a = AW'(a_r);      mul_b = BW'(dt_r);    end
      cts_pkg::STP_DELTA: begin mul_a = AW'(ss_r);     mul_b = BW'(dt_r);    end
      cts_pkg::STP_ANGLE: begin mul_a = AW'(asum_mag); mul_b = BW'(lock_r);  end
      cts_pkg::STP_JDIV:  begin div_n = DW'(p_r); div_d = DW'(jsum); end
      cts_pkg::STP_KDIV:  begin div_n = DW'(p_r); div_d = DW'(ksum); end
      cts_pkg::STP_CDIV:  begin div_n = DW'({p_r, 8'd0}); div_d = DW'(dt_r); end
      cts_pkg::STP_QDIV:  begin
        div_n = {nj_r, 8'd0};
        div_d = DW'({j_r, 24'd0}) + DW'(ad_r);
      end
      default: begin
        mul_a = '0;
      end
    endcase
    mul_start = cmd.start && !is_div && !is_sqrt;
    div_start = cmd.start && is_div;
    sq_start  = cmd.start && is_sqrt;
  end

  cts_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  cts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    sq_remw  = {sq_rem_r, sq_x_r[67:66]};
    sq_trial = {2'd0, sq_root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      sq_done_r <= 1'b0;
      sq_cnt_r  <= '0;
    end else begin
      sq_done_r <= 1'b0;
      if (sq_start) begin
        sq_busy_r <= 1'b1;
        sq_cnt_r  <= '0;
      end else if (sq_busy_r) begin
        sq_cnt_r <= sq_cnt_r + 6'd1;
        if (sq_cnt_r == 6'd33) begin
          sq_busy_r <= 1'b0;
          sq_done_r <= 1'b1;
        end
      end
    end
    if (sq_start) begin
      sq_x_r    <= {p_r, 4'd0};
      sq_root_r <= '0;
      sq_rem_r  <= '0;
    end else if (sq_busy_r) begin
      sq_x_r <= sq_x_r << 2;
      if (sq_remw >= sq_trial) begin
        sq_rem_r  <= 36'(sq_remw - sq_trial);
        sq_root_r <= {sq_root_r[32:0], 1'b1};
      end else begin
        sq_rem_r  <= sq_remw[35:0];
        sq_root_r <= {sq_root_r[32:0], 1'b0};
      end
    end
  end

  always_comb begin
    q_sat     = (|div_q[DW-1:64]) ? '1 : div_q[63:0];
    cdiv_mag  = (dt_r == 24'd0) ? ((p_r != 64'd0) ? '1 : 64'd0) : q_sat;
    qdiv_mag  = (j_r == 32'd0) ? ((|num_r[AW-1:80]) ? '1 : num_r[79:16]) : q_sat;
    sel_mag   = (cmd.step == cts_pkg::STP_CDIV) ? cdiv_mag : qdiv_mag;
    lim_c     = sel_mag > 64'(cap_r);
    clamp_mag = lim_c ? 64'(cap_r) : sel_mag;

    t1w = AW'(t1_r);
    t2w = mul_prod[AW-1:0];
    if (angle_r[31] == sneg_r) begin
      num_c = t1w + t2w;
      neg_c = sneg_r;
    end else if (t1w >= t2w) begin
      num_c = t1w - t2w;
      neg_c = angle_r[31];
    end else begin
      num_c = t2w - t1w;
      neg_c = sneg_r;
    end

    angm = mul_prod[49:16];
    if (asum[33]) begin
      na_c = (angm >= 34'h080000000) ? 32'h80000000 : 32'd0 - angm[31:0];
    end else begin
      na_c = (angm > 34'h07FFFFFFF) ? 32'h7FFFFFFF : angm[31:0];
    end

    if (mag_r == 64'd0) begin
      pack_c = 32'd0;
    end else if (neg_r) begin
      pack_c = (mag_r >= 64'h80000000) ? 32'h80000000 : 32'd0 - mag_r[31:0];
    end else begin
      pack_c = (mag_r > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= cts_pkg::MODE_CONSTRAINT;
      capf_r  <= 16'd4096;
      kc_r    <= '0;
      zeta_r  <= 16'd4096;
      dv_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cts_pkg::CFG_SIM_MODE:         mode_r <= cfg_data[1:0];
        cts_pkg::CFG_CAPACITY_FACTOR:  capf_r <= cfg_data[15:0];
        cts_pkg::CFG_CLUTCH_STIFFNESS: kc_r   <= cfg_data;
        cts_pkg::CFG_DAMPING_RATIO:    zeta_r <= cfg_data[15:0];
        cts_pkg::CFG_VISCOUS_DAMPING:  dv_r   <= cfg_data;
        default: begin
          mode_r <= mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
    end else if (cmd.capture) begin
      if (cmd.step == cts_pkg::STP_QDIV && mode_r == cts_pkg::MODE_FLUID) begin
        angle_r <= '0;
      end else if (cmd.step == cts_pkg::STP_ANGLE && !lim_r) begin
        angle_r <= na_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt_r   <= in_delta_time;
      jg_r   <= in_gearbox_inertia;
      je_r   <= in_engine_inertia;
      ks_r   <= in_shaft_stiffness;
      peak_r <= in_engine_peak_torque;
      lock_r <= lock_c;
      sneg_r <= slip_c[32];
      smag_r <= slip_c[32] ? slip_neg_c[31:0] : slip_c[31:0];
    end
    if (cmd.capture) begin
      case (cmd.step)
        cts_pkg::STP_CAP1:  cap_r <= 37'(mul_prod[47:12]);
        cts_pkg::STP_CAP2:  cap_r <= mul_prod[52:16];
        cts_pkg::STP_JMUL,
        cts_pkg::STP_KMUL,
        cts_pkg::STP_KJ,
        cts_pkg::STP_CMUL:  p_r <= mul_prod[63:0];
        cts_pkg::STP_JDIV:  j_r <= (jsum == 33'd0) ? 32'd0 : div_q[31:0];
        cts_pkg::STP_KDIV:  k_r <= (ksum == 33'd0) ? 32'd0 : div_q[31:0];
        cts_pkg::STP_SQRT:  s_r <= sq_root_r;
        cts_pkg::STP_DAMP:  a_r <= 41'(mul_prod[49:11]);
        cts_pkg::STP_ADT:   a_r <= a_r + 41'(mul_prod[55:20]);
        cts_pkg::STP_SS:    ss_r <= mul_prod[47:16];
        cts_pkg::STP_T1:    t1_r <= {mul_prod[62:0], 4'd0};
        cts_pkg::STP_T2: begin
          num_r <= num_c;
          neg_r <= neg_c;
        end
        cts_pkg::STP_FNUM: begin
          num_r <= AW'(mul_prod[63:0]);
          a_r   <= 41'(dv_r);
          neg_r <= sneg_r;
        end
        cts_pkg::STP_NJ:    nj_r <= mul_prod;
        cts_pkg::STP_AD:    ad_r <= mul_prod[64:0];
        cts_pkg::STP_DELTA: delta_r <= mul_prod[55:24];
        cts_pkg::STP_CDIV: begin
          mag_r <= clamp_mag;
          lim_r <= lim_c;
          neg_r <= sneg_r;
        end
        cts_pkg::STP_QDIV: begin
          mag_r <= clamp_mag;
          lim_r <= lim_c;
        end
        default: begin
          lim_r <= lim_r;
        end
      endcase
    end
    if (cmd.finish) begin
      torque_r  <= pack_c;
      limited_r <= lim_r;
    end
  end

  always_comb begin
    sts.done = mul_done || div_done || sq_done_r;
    sts.mode = mode_r;
  end

  assign out_clutch_torque    = torque_r;
  assign out_capacity_limited = limited_r;
endmodule

// ===== hw/rtl/cts_ctrl.sv =====
// Controller: item handshake and step sequencer for the datapath.
// Depends on cts_pkg for the state, step and command types.
module cts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output cts_pkg::cmd_t cmd,
  input  cts_pkg::sts_t sts
);
  cts_pkg::ctrl_state_t state_r, state_nxt;
  cts_pkg::step_t       step_r, step_nxt, step_follow;
  logic                 out_valid_r, out_valid_nxt;
  logic                 last_step, out_free;

  always_comb begin
    case (step_r)
      cts_pkg::STP_CAP1:  step_follow = cts_pkg::STP_CAP2;
      cts_pkg::STP_CAP2:  step_follow = cts_pkg::STP_JMUL;
      cts_pkg::STP_JMUL:  step_follow = cts_pkg::STP_JDIV;
      cts_pkg::STP_JDIV: begin
        if (sts.mode == cts_pkg::MODE_SPRING) begin
          step_follow = cts_pkg::STP_KMUL;
        end else if (sts.mode == cts_pkg::MODE_FLUID) begin
          step_follow = cts_pkg::STP_FNUM;
        end else begin
          step_follow = cts_pkg::STP_CMUL;
        end
      end
      cts_pkg::STP_CMUL:  step_follow = cts_pkg::STP_CDIV;
      cts_pkg::STP_FNUM:  step_follow = cts_pkg::STP_NJ;
      cts_pkg::STP_KMUL:  step_follow = cts_pkg::STP_KDIV;
      cts_pkg::STP_KDIV:  step_follow = cts_pkg::STP_KJ;
      cts_pkg::STP_KJ:    step_follow = cts_pkg::STP_SQRT;
      cts_pkg::STP_SQRT:  step_follow = cts_pkg::STP_DAMP;
      cts_pkg::STP_DAMP:  step_follow = cts_pkg::STP_ADT;
      cts_pkg::STP_ADT:   step_follow = cts_pkg::STP_SS;
      cts_pkg::STP_SS:    step_follow = cts_pkg::STP_T1;
      cts_pkg::STP_T1:    step_follow = cts_pkg::STP_T2;
      cts_pkg::STP_T2:    step_follow = cts_pkg::STP_NJ;
      cts_pkg::STP_NJ:    step_follow = cts_pkg::STP_AD;
      cts_pkg::STP_AD:    step_follow = cts_pkg::STP_QDIV;
      cts_pkg::STP_QDIV:  step_follow = cts_pkg::STP_DELTA;
      cts_pkg::STP_DELTA: step_follow = cts_pkg::STP_ANGLE;
      default:            step_follow = cts_pkg::STP_CAP1;
    endcase
    last_step = (step_r == cts_pkg::STP_CDIV) || (step_r == cts_pkg::STP_ANGLE) ||
                (step_r == cts_pkg::STP_QDIV && sts.mode == cts_pkg::MODE_FLUID);
    out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      cts_pkg::CS_IDLE: begin
        if (in_valid) begin
          state_nxt = cts_pkg::CS_LAUNCH;
          step_nxt  = cts_pkg::STP_CAP1;
        end
      end
      cts_pkg::CS_LAUNCH: state_nxt = cts_pkg::CS_WAIT;
      cts_pkg::CS_WAIT: begin
        if (sts.done) begin
          if (last_step) begin
            state_nxt = cts_pkg::CS_FINISH;
          end else begin
            state_nxt = cts_pkg::CS_LAUNCH;
            step_nxt  = step_follow;
          end
        end
      end
      cts_pkg::CS_FINISH: begin
        if (out_free) begin
          state_nxt = cts_pkg::CS_IDLE;
        end
      end
      default: state_nxt = cts_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    cmd.load    = 1'b0;
    cmd.start   = 1'b0;
    cmd.capture = 1'b0;
    cmd.finish  = 1'b0;
    cmd.step    = step_r;
    in_stall    = 1'b1;
    case (state_r)
      cts_pkg::CS_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      cts_pkg::CS_LAUNCH: cmd.start   = 1'b1;
      cts_pkg::CS_WAIT:   cmd.capture = sts.done;
      cts_pkg::CS_FINISH: cmd.finish  = out_free;
      default:            in_stall    = 1'b1;
    endcase
    out_valid_nxt = cmd.finish || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cts_pkg::CS_IDLE;
      step_r      <= cts_pkg::STP_CAP1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

// ===== hw/rtl/clutch_torque_solver.sv =====
// Clutch torque solver top level: controller plus datapath.
// Depends on cts_pkg, cts_ctrl and cts_datapath.
//
//   port group  direction  handshake           payload
//   in_*        input      in_valid/in_stall   substep inputs, one item per substep
//   out_*       output     out_valid/out_stall clutch torque and capacity flag
//   cfg_*       input      cfg_valid/cfg_ready register index and write data
//
// One item at a time. Each item runs as a sequence of multiply, divide and root steps;
// constraint mode takes the fewest steps and spring mode the most.
// The serial 128-bit divider is the slowest of the units.
// Reset is synchronous; it clears the twist angle and loads register defaults.
// A stalled result sits in the output register; a new item is taken meanwhile,
// and its result waits in the finish state until the register frees.
module clutch_torque_solver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [23:0]                   in_delta_time,
  input  logic [16:0]                   in_clutch_pedal,
  input  logic signed [31:0]            in_gearbox_speed,
  input  logic [31:0]                   in_gearbox_inertia,
  input  logic                          in_gear_engaged,
  input  logic [31:0]                   in_shaft_stiffness,
  input  logic signed [31:0]            in_engine_speed,
  input  logic [31:0]                   in_engine_inertia,
  input  logic [31:0]                   in_engine_peak_torque,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_clutch_torque,
  output logic                          out_capacity_limited,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  cts_pkg::cmd_t cmd;
  cts_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  cts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  cts_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_delta_time         (in_delta_time),
    .in_clutch_pedal       (in_clutch_pedal),
    .in_gearbox_speed      (in_gearbox_speed),
    .in_gearbox_inertia    (in_gearbox_inertia),
    .in_gear_engaged       (in_gear_engaged),
    .in_shaft_stiffness    (in_shaft_stiffness),
    .in_engine_speed       (in_engine_speed),
    .in_engine_inertia     (in_engine_inertia),
    .in_engine_peak_torque (in_engine_peak_torque),
    .out_clutch_torque     (out_clutch_torque),
    .out_capacity_limited  (out_capacity_limited)
  );
endmodule

// ===== bench/tb_top.sv =====
// Testbench for clutch_torque_solver: directed and random substeps in all modes.
// Depends on cts_pkg and the clutch_torque_solver RTL; checks against its own predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef logic [127:0] wide_t;

  typedef struct {
    logic [23:0]        dt;
    logic [16:0]        pedal;
    logic signed [31:0] vg;
    logic [31:0]        jg;
    logic               gear;
    logic [31:0]        ks;
    logic signed [31:0] ve;
    logic [31:0]        je;
    logic [31:0]        peak;
  } substep_t;

  typedef struct {
    logic signed [31:0] torque;
    logic               limited;
  } torque_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [23:0] in_delta_time;
  logic [16:0] in_clutch_pedal;
  logic signed [31:0] in_gearbox_speed;
  logic [31:0] in_gearbox_inertia;
  logic in_gear_engaged;
  logic [31:0] in_shaft_stiffness;
  logic signed [31:0] in_engine_speed;
  logic [31:0] in_engine_inertia;
  logic [31:0] in_engine_peak_torque;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_clutch_torque;
  logic out_capacity_limited;
  logic cfg_valid;
  logic cfg_ready;
  logic [cts_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  logic [1:0]  mdl_mode;
  logic [63:0] mdl_cap_factor, mdl_kc, mdl_zeta, mdl_dv;
  logic signed [31:0] mdl_twist;

  torque_t torque_q[$];
  int unsigned fail_count;
  bit quiet;
  int unsigned hold_cycles;

  clutch_torque_solver u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [63:0] sat64(wide_t x);
    return (x[127:64] != 0) ? MAX64 : x[63:0];
  endfunction

  function automatic logic [63:0] series_of(logic [63:0] a, logic [63:0] b);
    wide_t s;
    s = wide_t'(a) + wide_t'(b);
    if (s == 0) return 0;
    return sat64((wide_t'(a) * wide_t'(b)) / s);
  endfunction

  function automatic logic [63:0] floor_root(wide_t x);
    logic [63:0] root, trial;
    wide_t rem;
    root = 0;
    rem = 0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | wide_t'(x[2*i +: 2]);
      trial = (root << 2) | 64'd1;
      if (rem >= wide_t'(trial)) begin
        rem = rem - wide_t'(trial);
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [63:0] implicit_mag(wide_t num, logic [63:0] a, logic [63:0] j,
                                               logic [63:0] dt);
    wide_t n, d;
    if (j == 0) return sat64(num >> 16);
    n = (num * wide_t'(j)) << 8;
    d = (wide_t'(j) << 24) + wide_t'(a) * wide_t'(dt);
    return sat64(n / d);
  endfunction

  function automatic logic [31:0] pack_torque(logic neg, logic [63:0] mag);
    if (mag == 0) return 0;
    if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  function automatic torque_t predict_torque(substep_t s);
    torque_t r;
    logic [63:0] pedal, lock, cap, j, mag, smag, k, sq, d, a, ss, amag, dt;
    longint slip, delta, na;
    logic sneg, neg, lim, aneg;
    wide_t t1, t2, num, p;
    dt = 64'(s.dt);
    pedal = (s.pedal > 17'd65536) ? 64'd65536 : 64'(s.pedal);
    lock = s.gear ? 64'd65536 - pedal : 64'd0;
    cap = (((64'(s.peak) * mdl_cap_factor) >> 12) * lock) >> 16;
    slip = longint'(s.ve) - longint'(s.vg);
    sneg = slip < 0;
    smag = sneg ? 64'(-slip) : 64'(slip);
    j = series_of(64'(s.jg), 64'(s.je));
    if (mdl_mode == cts_pkg::MODE_SPRING) begin
      k = series_of(64'(s.ks), mdl_kc);
      sq = floor_root((wide_t'(k) * wide_t'(j)) << 4);
      d = (64'd2 * sq * mdl_zeta) >> 12;
      a = ((k * dt) >> 20) + d;
      ss = (smag * lock) >> 16;
      aneg = mdl_twist < 0;
      amag = aneg ? 64'(-longint'(mdl_twist)) : 64'(longint'(mdl_twist));
      t1 = wide_t'(k * amag) << 4;
      t2 = wide_t'(a) * wide_t'(ss);
      if (aneg == sneg) begin
        num = t1 + t2;
        neg = sneg;
      end else if (t1 >= t2) begin
        num = t1 - t2;
        neg = aneg;
      end else begin
        num = t2 - t1;
        neg = sneg;
      end
      mag = implicit_mag(num, a, j, dt);
      lim = mag > cap;
      if (lim) begin
        mag = cap;
      end else begin
        delta = longint'((ss * dt) >> 24);
        if (sneg) delta = -delta;
        na = ((longint'(mdl_twist) + delta) * longint'(lock)) / 65536;
        if (na > 64'sd2147483647) na = 64'sd2147483647;
        if (na < -64'sd2147483648) na = -64'sd2147483648;
        mdl_twist = 32'(na);
      end
    end else if (mdl_mode == cts_pkg::MODE_FLUID) begin
      mdl_twist = 0;
      neg = sneg;
      mag = implicit_mag(wide_t'(mdl_dv) * wide_t'(smag), mdl_dv, j, dt);
      lim = mag > cap;
      if (lim) mag = cap;
    end else begin
      p = wide_t'(smag) * wide_t'(j);
      neg = sneg;
      if (dt == 0) mag = (p != 0) ? MAX64 : 64'd0;
      else mag = sat64((p << 8) / wide_t'(dt));
      lim = mag > cap;
      if (lim) mag = cap;
    end
    r.torque = pack_torque(neg, mag);
    r.limited = lim;
    return r;
  endfunction

  always @(posedge clk) begin
    torque_t exp_t;
    if (out_valid && !out_stall) begin
      if (torque_q.size() == 0) begin
        $error("unexpected item: clutch_torque %0d", out_clutch_torque);
        fail_count++;
      end else begin
        exp_t = torque_q.pop_front();
        if (out_clutch_torque !== exp_t.torque) begin
          $error("clutch_torque expected %0d actual %0d", exp_t.torque, out_clutch_torque);
          fail_count++;
        end
        if (out_capacity_limited !== exp_t.limited) begin
          $error("capacity_limited expected %0b actual %0b", exp_t.limited,
                 out_capacity_limited);
          fail_count++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 9);
    end
  end

  task automatic send_substep(substep_t s);
    while (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_delta_time <= s.dt;
    in_clutch_pedal <= s.pedal;
    in_gearbox_speed <= s.vg;
    in_gearbox_inertia <= s.jg;
    in_gear_engaged <= s.gear;
    in_shaft_stiffness <= s.ks;
    in_engine_speed <= s.ve;
    in_engine_inertia <= s.je;
    in_engine_peak_torque <= s.peak;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    torque_q.push_back(predict_torque(s));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    wait (torque_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [cts_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cts_pkg::CFG_SIM_MODE:         mdl_mode = val[1:0];
      cts_pkg::CFG_CAPACITY_FACTOR:  mdl_cap_factor = 64'(val[15:0]);
      cts_pkg::CFG_CLUTCH_STIFFNESS: mdl_kc = 64'(val);
      cts_pkg::CFG_DAMPING_RATIO:    mdl_zeta = 64'(val[15:0]);
      cts_pkg::CFG_VISCOUS_DAMPING:  mdl_dv = 64'(val);
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [1:0] mode, logic [15:0] capf, logic [31:0] kc,
                          logic [15:0] zeta, logic [31:0] dv);
    drain();
    write_reg(cts_pkg::CFG_SIM_MODE, 32'(mode));
    write_reg(cts_pkg::CFG_CAPACITY_FACTOR, 32'(capf));
    write_reg(cts_pkg::CFG_CLUTCH_STIFFNESS, kc);
    write_reg(cts_pkg::CFG_DAMPING_RATIO, 32'(zeta));
    write_reg(cts_pkg::CFG_VISCOUS_DAMPING, dv);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h000F_FFFF);
      3: return $urandom_range(32'h0001_0000, 32'h0100_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_speed();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic substep_t random_substep();
    substep_t s;
    case ($urandom_range(0, 7))
      0: s.dt = 24'd0;
      1: s.dt = 24'hFF_FFFF;
      2: s.dt = 24'($urandom);
      default: s.dt = 24'($urandom_range(1, 24'h00_4000));
    endcase
    case ($urandom_range(0, 5))
      0: s.pedal = 17'($urandom_range(0, 17'h1_FFFF));
      1: s.pedal = 17'd65536;
      2: s.pedal = 17'd0;
      default: s.pedal = 17'($urandom_range(0, 65536));
    endcase
    s.vg = pick_speed();
    s.ve = pick_speed();
    s.jg = pick32();
    s.je = pick32();
    s.ks = pick32();
    s.peak = pick32();
    s.gear = $urandom_range(0, 9) != 0;
    return s;
  endfunction

  function automatic substep_t make_substep(logic [23:0] dt, logic [16:0] pedal,
                                            logic [31:0] vg, logic [31:0] jg, logic gear,
                                            logic [31:0] ks, logic [31:0] ve,
                                            logic [31:0] je, logic [31:0] peak);
    substep_t s;
    s.dt = dt; s.pedal = pedal; s.vg = vg; s.jg = jg; s.gear = gear;
    s.ks = ks; s.ve = ve; s.je = je; s.peak = peak;
    return s;
  endfunction

  task automatic test_directed;
    logic [1:0] modes[4];
    modes = '{cts_pkg::MODE_CONSTRAINT, cts_pkg::MODE_SPRING, cts_pkg::MODE_FLUID,
              MODE_UNUSED};
    foreach (modes[m]) begin
      set_regs(modes[m], 16'd4096, 32'h0010_0000, 16'd4096, 32'h0002_0000);
      send_substep(make_substep(24'h00_4000, 17'd0, 32'h0001_0000, 32'h0001_0000, 1'b1,
                                32'h0010_0000, 32'h0064_0000, 32'h0000_8000, 32'h0064_0000));
      send_substep(make_substep(24'h00_4000, 17'h1_FFFF, 32'h0, 32'h1_0000, 1'b1,
                                32'h1000, 32'h10_0000, 32'h1_0000, 32'h10_0000));
      send_substep(make_substep(24'h00_1000, 17'd0, 32'h0, 32'h0, 1'b1,
                                32'h0, 32'h0100_0000, 32'h0, 32'hFFFF_FFFF));
      send_substep(make_substep(24'd0, 17'd0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
                                32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_substep(make_substep(24'hFF_FFFF, 17'd32768, 32'h7FFF_FFFF, 32'h1, 1'b0,
                                32'h1, 32'h8000_0000, 32'h0, 32'h1234_5678));
    end
    set_regs(cts_pkg::MODE_SPRING, 16'hFFFF, 32'h0, 16'd0, 32'hFFFF_FFFF);
    send_substep(make_substep(24'h00_4000, 17'd0, 32'h0, 32'h1_0000, 1'b1,
                              32'h0, 32'h0050_0000, 32'h1_0000, 32'hFFFF_FFFF));
    send_substep(make_substep(24'h00_4000, 17'd1000, 32'h0050_0000, 32'h1_0000, 1'b1,
                              32'h8000, 32'h0, 32'h1_0000, 32'hFFFF_FFFF));
  endtask

  task automatic test_backpressure;
    set_regs(cts_pkg::MODE_CONSTRAINT, 16'd4096, 32'h0, 16'd4096, 32'h0);
    quiet = 1'b1;
    hold_cycles = 3000;
    repeat (6) send_substep(random_substep());
    quiet = 1'b0;
  endtask

  task automatic test_random_phases;
    logic [1:0] mode;
    for (int ph = 0; ph < 12; ph++) begin
      mode = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
      set_regs(mode,
               (ph == 4) ? 16'd0 : (ph == 5) ? 16'hFFFF : 16'($urandom_range(0, 16'h2000)),
               (ph == 6) ? 32'hFFFF_FFFF : pick32(),
               (ph == 7) ? 16'hFFFF : 16'($urandom),
               (ph == 8) ? 32'hFFFF_FFFF : pick32());
      quiet = (ph == 2);
      repeat (152) send_substep(random_substep());
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_delta_time = '0;
    in_clutch_pedal = '0;
    in_gearbox_speed = '0;
    in_gearbox_inertia = '0;
    in_gear_engaged = 1'b0;
    in_shaft_stiffness = '0;
    in_engine_speed = '0;
    in_engine_inertia = '0;
    in_engine_peak_torque = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    quiet = 1'b0;
    hold_cycles = 0;
    mdl_mode = cts_pkg::MODE_CONSTRAINT;
    mdl_cap_factor = 64'd4096;
    mdl_kc = 64'd0;
    mdl_zeta = 64'd4096;
    mdl_dv = 64'd0;
    mdl_twist = 32'sd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (1000) @(posedge clk);
    if (fail_count == 0 && torque_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
